### hw/rtl/tvfm_pkg.sv
// Shared constants, types and arithmetic helpers for the thrust vector force/moment unit
`timescale 1ns / 1ps

package tvfm_pkg;

    // CORDIC depth; the arctangent table stops at 24 entries
    localparam int CORDIC_STAGES = 16;
    localparam int TABLE_LEN     = 24;
    localparam int CORDIC_ITER   = (CORDIC_STAGES < TABLE_LEN) ? CORDIC_STAGES : TABLE_LEN;

    // Pipeline stage numbers
    localparam int ST_CLAMP = 0;
    localparam int ST_SC    = CORDIC_ITER + 1;
    localparam int ST_MULA  = CORDIC_ITER + 2;
    localparam int ST_FZ    = CORDIC_ITER + 3;
    localparam int ST_FXY   = CORDIC_ITER + 4;
    localparam int ST_MPP   = CORDIC_ITER + 5;
    localparam int ST_MSUM  = CORDIC_ITER + 6;
    localparam int ST_OUT   = CORDIC_ITER + 7;
    localparam int NSTG     = CORDIC_ITER + 8;

    // 1/K in Q2.30 and angle constants in 1/256 degree
    localparam logic signed [32:0] CORDIC_X0    = 33'sd652032874;
    localparam logic signed [17:0] QUARTER_TURN = 18'sd23040;
    localparam logic signed [17:0] HALF_TURN    = 18'sd46080;

    typedef enum logic [1:0] {
        REG_ENABLE = 2'd0,
        REG_LIMIT  = 2'd1,
        REG_GAIN   = 2'd2,
        REG_GIMBAL = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic              flip;
        logic signed [29:0] z;
    } angle_t;

    // atan(2^-i) in 2^-20 degree
    function automatic logic signed [29:0] atan_step(input logic [4:0] idx);
        logic signed [29:0] r;
        unique case (idx)
            5'd0:    r = 30'sd47185920;
            5'd1:    r = 30'sd27855475;
            5'd2:    r = 30'sd14718068;
            5'd3:    r = 30'sd7471121;
            5'd4:    r = 30'sd3750058;
            5'd5:    r = 30'sd1876857;
            5'd6:    r = 30'sd938658;
            5'd7:    r = 30'sd469357;
            5'd8:    r = 30'sd234682;
            5'd9:    r = 30'sd117342;
            5'd10:   r = 30'sd58671;
            5'd11:   r = 30'sd29335;
            5'd12:   r = 30'sd14668;
            5'd13:   r = 30'sd7334;
            5'd14:   r = 30'sd3667;
            5'd15:   r = 30'sd1833;
            5'd16:   r = 30'sd917;
            5'd17:   r = 30'sd458;
            5'd18:   r = 30'sd229;
            5'd19:   r = 30'sd115;
            5'd20:   r = 30'sd57;
            5'd21:   r = 30'sd29;
            5'd22:   r = 30'sd14;
            5'd23:   r = 30'sd7;
            default: r = 30'sd0;
        endcase
        return r;
    endfunction

    // Clamp a command to +/- limit
    function automatic logic signed [15:0] clamp_cmd(input logic signed [15:0] cmd,
                                                     input logic [14:0] lim);
        logic signed [16:0] c;
        logic signed [16:0] l;
        logic signed [16:0] nl;
        logic signed [15:0] r;
        c  = {cmd[15], cmd};
        l  = {2'b00, lim};
        nl = -l;
        if (c > l) begin
            r = l[15:0];
        end else if (c < nl) begin
            r = nl[15:0];
        end else begin
            r = cmd;
        end
        return r;
    endfunction

    // Fold the angle into +/- 90 degrees and scale to 2^-20 degree
    function automatic angle_t reduce_angle(input logic signed [15:0] a);
        logic signed [17:0] a18;
        logic signed [17:0] r;
        angle_t             res;
        a18      = {{2{a[15]}}, a};
        res.flip = 1'b0;
        if (a18 > QUARTER_TURN) begin
            r        = HALF_TURN - a18;
            res.flip = 1'b1;
        end else if (a18 < -QUARTER_TURN) begin
            r        = -HALF_TURN - a18;
            res.flip = 1'b1;
        end else begin
            r = a18;
        end
        res.z = {r, 12'b0};
        return res;
    endfunction

    // Round a Q2.30 CORDIC output to Q1.15, optional negate, saturate
    function automatic logic signed [15:0] round_q15(input logic signed [32:0] v,
                                                     input logic neg);
        logic signed [33:0] s;
        logic signed [18:0] t;
        logic signed [19:0] u;
        logic signed [15:0] r;
        s = {v[32], v} + 34'sd16384;
        t = s[33:15];
        u = neg ? -{t[18], t} : {t[18], t};
        if (u > 20'sd32767) begin
            r = 16'sh7fff;
        end else if (u < -20'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = u[15:0];
        end
        return r;
    endfunction

    // floor((v + 2^14) / 2^15), saturated to 40 bits
    function automatic logic signed [39:0] rnd15_sat40(input logic signed [63:0] v);
        logic signed [63:0] r;
        logic signed [39:0] o;
        r = (v + 64'sd16384) >>> 15;
        if (r > 64'sd549755813887) begin
            o = 40'sh7fffffffff;
        end else if (r < -64'sd549755813888) begin
            o = 40'sh8000000000;
        end else begin
            o = r[39:0];
        end
        return o;
    endfunction

    // floor((p + 2^15) / 2^16), saturated to 48 bits
    function automatic logic signed [47:0] round_sat48(input logic signed [73:0] p);
        logic signed [73:0] r;
        logic signed [47:0] o;
        r = (p + 74'sd32768) >>> 16;
        if (r > 74'sd140737488355327) begin
            o = 48'sh7fffffffffff;
        end else if (r < -74'sd140737488355328) begin
            o = 48'sh800000000000;
        end else begin
            o = r[47:0];
        end
        return o;
    endfunction

endpackage

### hw/rtl/thrust_vector_force_moment_unit.sv
// Top level: gimbal clamp, pipelined CORDIC sin/cos, force and moment datapath
`timescale 1ns / 1ps

// Thrust vector force/moment unit. Takes one item per clock while the output is not
// stalled and returns one result per item, passing through one clamp stage, one stage
// per CORDIC iteration, then six multiply/round stages and the output register.
// Every stage has its own valid bit and moves on its own, so a stall at the output
// only holds items until the bubbles ahead of them are filled. Config
// registers are written through cfg_we/cfg_index/cfg_data and must only change while
// no item is in flight. With enable low every result field is zero.
module thrust_vector_force_moment_unit
    import tvfm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] pitch_command,
    input  logic signed [15:0] yaw_command,
    input  logic [31:0]        thrust,
    input  logic signed [31:0] cg_position,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [15:0] pitch_deflection,
    output logic signed [15:0] yaw_deflection,
    output logic signed [39:0] force_x,
    output logic signed [39:0] force_y,
    output logic signed [39:0] force_z,
    output logic signed [47:0] moment_pitch,
    output logic signed [47:0] moment_yaw
);

    // Config registers
    logic               enable_reg;
    logic [14:0]        limit_reg;
    logic [15:0]        gain_reg;
    logic signed [31:0] gimbal_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            limit_reg  <= 15'd2560;
            gain_reg   <= 16'd4096;
            gimbal_reg <= 32'sd0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_ENABLE: enable_reg <= cfg_data[0];
                REG_LIMIT:  limit_reg  <= cfg_data[14:0];
                REG_GAIN:   gain_reg   <= cfg_data[15:0];
                REG_GIMBAL: gimbal_reg <= cfg_data;
            endcase
        end
    end

    // Stage valid bits and per-stage load enables
    logic [NSTG-1:0] v_reg;
    logic [NSTG-1:0] en;

    always_comb
    begin
        en[NSTG-1] = !v_reg[NSTG-1] || out_ready;
        for (int k = NSTG - 2; k >= 0; k--)
        begin
            en[k] = !v_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < NSTG; k++)
            begin
                if (en[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NSTG-1];

    // Side pipes: deflections, scaled thrust, arm
    logic signed [15:0] pdef_reg [0:ST_MSUM];
    logic signed [15:0] ydef_reg [0:ST_MSUM];
    logic [36:0]        thr_reg  [0:ST_MULA];
    logic signed [32:0] arm_reg  [0:ST_FXY];

    // CORDIC state, index 0 is the clamp stage output
    logic signed [32:0] px_reg [0:CORDIC_ITER];
    logic signed [32:0] py_reg [0:CORDIC_ITER];
    logic signed [29:0] pz_reg [0:CORDIC_ITER];
    logic signed [32:0] yx_reg [0:CORDIC_ITER];
    logic signed [32:0] yy_reg [0:CORDIC_ITER];
    logic signed [29:0] yz_reg [0:CORDIC_ITER];
    logic               pflip_reg [0:CORDIC_ITER];
    logic               yflip_reg [0:CORDIC_ITER];

    // Clamp stage
    logic signed [15:0] pclamp;
    logic signed [15:0] yclamp;
    angle_t             pang;
    angle_t             yang;
    logic [47:0]        tg_prod;
    logic [48:0]        tg_sum;

    always_comb
    begin
        pclamp  = clamp_cmd(pitch_command, limit_reg);
        yclamp  = clamp_cmd(yaw_command, limit_reg);
        pang    = reduce_angle(pclamp);
        yang    = reduce_angle(yclamp);
        tg_prod = thrust * gain_reg;
        tg_sum  = {1'b0, tg_prod} + 49'd2048;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_CLAMP])
        begin
            pdef_reg[0]  <= pclamp;
            ydef_reg[0]  <= yclamp;
            thr_reg[0]   <= tg_sum[48:12];
            arm_reg[0]   <= 33'(gimbal_reg) - 33'(cg_position);
            px_reg[0]    <= CORDIC_X0;
            py_reg[0]    <= 33'sd0;
            pz_reg[0]    <= pang.z;
            pflip_reg[0] <= pang.flip;
            yx_reg[0]    <= CORDIC_X0;
            yy_reg[0]    <= 33'sd0;
            yz_reg[0]    <= yang.z;
            yflip_reg[0] <= yang.flip;
        end
    end

    // Side pipe shifting
    genvar j;
    generate
        for (j = 1; j <= ST_MSUM; j++)
        begin : g_defl
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    pdef_reg[j] <= pdef_reg[j-1];
                    ydef_reg[j] <= ydef_reg[j-1];
                end
            end
        end
        for (j = 1; j <= ST_MULA; j++)
        begin : g_thr
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    thr_reg[j] <= thr_reg[j-1];
                end
            end
        end
        for (j = 1; j <= ST_FXY; j++)
        begin : g_arm
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    arm_reg[j] <= arm_reg[j-1];
                end
            end
        end

        // One CORDIC rotation per stage, both angles side by side
        for (j = 1; j <= CORDIC_ITER; j++)
        begin : g_cordic
            always_ff @(posedge clk)
            begin
                if (en[j])
                begin
                    pflip_reg[j] <= pflip_reg[j-1];
                    yflip_reg[j] <= yflip_reg[j-1];
                    if (pz_reg[j-1] >= 30'sd0)
                    begin
                        px_reg[j] <= px_reg[j-1] - (py_reg[j-1] >>> (j - 1));
                        py_reg[j] <= py_reg[j-1] + (px_reg[j-1] >>> (j - 1));
                        pz_reg[j] <= pz_reg[j-1] - atan_step(5'(j - 1));
                    end
                    else
                    begin
                        px_reg[j] <= px_reg[j-1] + (py_reg[j-1] >>> (j - 1));
                        py_reg[j] <= py_reg[j-1] - (px_reg[j-1] >>> (j - 1));
                        pz_reg[j] <= pz_reg[j-1] + atan_step(5'(j - 1));
                    end
                    if (yz_reg[j-1] >= 30'sd0)
                    begin
                        yx_reg[j] <= yx_reg[j-1] - (yy_reg[j-1] >>> (j - 1));
                        yy_reg[j] <= yy_reg[j-1] + (yx_reg[j-1] >>> (j - 1));
                        yz_reg[j] <= yz_reg[j-1] - atan_step(5'(j - 1));
                    end
                    else
                    begin
                        yx_reg[j] <= yx_reg[j-1] + (yy_reg[j-1] >>> (j - 1));
                        yy_reg[j] <= yy_reg[j-1] - (yx_reg[j-1] >>> (j - 1));
                        yz_reg[j] <= yz_reg[j-1] + atan_step(5'(j - 1));
                    end
                end
            end
        end
    endgenerate

    // Sine/cosine rounding to Q1.15
    logic signed [15:0] se_reg;
    logic signed [15:0] ce_reg;
    logic signed [15:0] sz_reg;
    logic signed [15:0] cz_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_SC])
        begin
            se_reg <= round_q15(py_reg[CORDIC_ITER], 1'b0);
            ce_reg <= round_q15(px_reg[CORDIC_ITER], pflip_reg[CORDIC_ITER]);
            sz_reg <= round_q15(yy_reg[CORDIC_ITER], 1'b0);
            cz_reg <= round_q15(yx_reg[CORDIC_ITER], yflip_reg[CORDIC_ITER]);
        end
    end

    // Cosine products and se * thrust
    logic signed [31:0] cc_prod;
    logic signed [31:0] cs_prod;
    logic signed [32:0] cc_sum;
    logic signed [32:0] cs_sum;
    logic signed [37:0] thr_a;
    logic signed [53:0] st_prod;
    logic signed [16:0] rcc_reg;
    logic signed [16:0] rcs_reg;
    logic signed [53:0] st_reg;

    always_comb
    begin
        cc_prod = ce_reg * cz_reg;
        cs_prod = ce_reg * sz_reg;
        cc_sum  = {cc_prod[31], cc_prod} + 33'sd16384;
        cs_sum  = {cs_prod[31], cs_prod} + 33'sd16384;
        thr_a   = {1'b0, thr_reg[ST_SC]};
        st_prod = se_reg * thr_a;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MULA])
        begin
            rcc_reg <= cc_sum[31:15];
            rcs_reg <= cs_sum[31:15];
            st_reg  <= st_prod;
        end
    end

    // Force z rounding, x/y thrust products
    logic signed [37:0] thr_b;
    logic signed [54:0] fxp_prod;
    logic signed [54:0] fyp_prod;
    logic signed [54:0] fxp_reg;
    logic signed [54:0] fyp_reg;
    logic signed [39:0] fz_reg;

    always_comb
    begin
        thr_b    = {1'b0, thr_reg[ST_MULA]};
        fxp_prod = rcc_reg * thr_b;
        fyp_prod = rcs_reg * thr_b;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_FZ])
        begin
            fz_reg  <= rnd15_sat40(-(64'(st_reg)));
            fxp_reg <= fxp_prod;
            fyp_reg <= fyp_prod;
        end
    end

    // Force x/y rounding
    logic signed [39:0] fx_reg;
    logic signed [39:0] fy_reg;
    logic signed [39:0] fz2_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_FXY])
        begin
            fx_reg  <= rnd15_sat40(64'(fxp_reg));
            fy_reg  <= rnd15_sat40(64'(fyp_reg));
            fz2_reg <= fz_reg;
        end
    end

    // Moment partial products: arm times low and high force halves
    logic signed [20:0] fz_lo;
    logic signed [19:0] fz_hi;
    logic signed [20:0] fy_lo;
    logic signed [19:0] fy_hi;
    logic signed [53:0] mpl_prod;
    logic signed [52:0] mph_prod;
    logic signed [53:0] myl_prod;
    logic signed [52:0] myh_prod;
    logic signed [53:0] mpl_reg;
    logic signed [52:0] mph_reg;
    logic signed [53:0] myl_reg;
    logic signed [52:0] myh_reg;
    logic signed [39:0] fx3_reg;
    logic signed [39:0] fy3_reg;
    logic signed [39:0] fz3_reg;

    always_comb
    begin
        fz_lo    = $signed({1'b0, fz2_reg[19:0]});
        fz_hi    = fz2_reg[39:20];
        fy_lo    = $signed({1'b0, fy_reg[19:0]});
        fy_hi    = fy_reg[39:20];
        mpl_prod = arm_reg[ST_FXY] * fz_lo;
        mph_prod = arm_reg[ST_FXY] * fz_hi;
        myl_prod = arm_reg[ST_FXY] * fy_lo;
        myh_prod = arm_reg[ST_FXY] * fy_hi;
    end

    always_ff @(posedge clk)
    begin
        if (en[ST_MPP])
        begin
            mpl_reg <= mpl_prod;
            mph_reg <= mph_prod;
            myl_reg <= myl_prod;
            myh_reg <= myh_prod;
            fx3_reg <= fx_reg;
            fy3_reg <= fy_reg;
            fz3_reg <= fz2_reg;
        end
    end

    // Full moment products; yaw takes the negated arm
    logic signed [73:0] mp_sum_reg;
    logic signed [73:0] my_sum_reg;
    logic signed [39:0] fx4_reg;
    logic signed [39:0] fy4_reg;
    logic signed [39:0] fz4_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_MSUM])
        begin
            mp_sum_reg <= (74'(mph_reg) <<< 20) + 74'(mpl_reg);
            my_sum_reg <= -((74'(myh_reg) <<< 20) + 74'(myl_reg));
            fx4_reg    <= fx3_reg;
            fy4_reg    <= fy3_reg;
            fz4_reg    <= fz3_reg;
        end
    end

    // Output register, zeroed while disabled
    logic signed [15:0] pdef_out_reg;
    logic signed [15:0] ydef_out_reg;
    logic signed [39:0] fx_out_reg;
    logic signed [39:0] fy_out_reg;
    logic signed [39:0] fz_out_reg;
    logic signed [47:0] mp_out_reg;
    logic signed [47:0] my_out_reg;

    always_ff @(posedge clk)
    begin
        if (en[ST_OUT])
        begin
            if (enable_reg)
            begin
                pdef_out_reg <= pdef_reg[ST_MSUM];
                ydef_out_reg <= ydef_reg[ST_MSUM];
                fx_out_reg   <= fx4_reg;
                fy_out_reg   <= fy4_reg;
                fz_out_reg   <= fz4_reg;
                mp_out_reg   <= round_sat48(mp_sum_reg);
                my_out_reg   <= round_sat48(my_sum_reg);
            end
            else
            begin
                pdef_out_reg <= '0;
                ydef_out_reg <= '0;
                fx_out_reg   <= '0;
                fy_out_reg   <= '0;
                fz_out_reg   <= '0;
                mp_out_reg   <= '0;
                my_out_reg   <= '0;
            end
        end
    end

    assign pitch_deflection = pdef_out_reg;
    assign yaw_deflection   = ydef_out_reg;
    assign force_x          = fx_out_reg;
    assign force_y          = fy_out_reg;
    assign force_z          = fz_out_reg;
    assign moment_pitch     = mp_out_reg;
    assign moment_yaw       = my_out_reg;

`ifndef SYNTHESIS
    // Input is refused only when every stage holds an item
    a_full_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> ($countones(v_reg) == NSTG))
        else $error("input stalled with a bubble in the pipeline");

    // Disabled forces, moments and pitch deflection are all zero
    a_disabled_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !enable_reg) |-> (force_x == '0 && force_y == '0 && force_z == '0
            && moment_pitch == '0 && moment_yaw == '0 && pitch_deflection == '0))
        else $error("nonzero result while disabled");

    // Reported pitch deflection stays within the configured limit
    a_defl_limit: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && enable_reg) |->
            ($signed({pitch_deflection[15], pitch_deflection}) <= $signed({2'b00, limit_reg})
            && $signed({pitch_deflection[15], pitch_deflection})
                >= -$signed({2'b00, limit_reg})))
        else $error("pitch deflection outside limit");
`endif

endmodule
